FILE: rtl/keyframe_vector_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Keyframe vector interpolator assertion macros
// Shared wrappers for the concurrent checks of the interpolator.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_MACROS_SVH

// check that is switched off while reset is low
`define KVI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs across reset
`define KVI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/kvi_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe vector interpolator package
// Sizes, codes, key record and sequencer states shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package kvi_pkg;

  localparam int MAX_KEYS   = 64;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_KEYS);
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 32;
  localparam int PROD_W     = VAL_W + 1 + FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_BEFORE = 2'd2;
  localparam logic [1:0] ST_AFTER  = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] tstamp;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
  } kvi_key_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_DIV,
    S_MUL_GO,
    S_MUL_WAIT,
    S_OUT
  } kvi_state_t;

endpackage

`default_nettype wire

FILE: rtl/keyframe_vector_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe vector interpolator
// Key table, linear key search, serial factor divider and shared blend unit.
// ----------------------------------------------------------------------------
// A load transaction writes one key in the cycle it is accepted and gives no
// result. A query walks the keys in use one per cycle from key 0 (one table
// read port), then runs a serial divide for the factor and blends the three
// components one after another through a single 3-stage multiplier. One
// query is in flight at a time; in_stall is high until its result is placed
// in the output register.
`default_nettype none

`include "keyframe_vector_interpolator_macros.svh"

module keyframe_vector_interpolator
  import kvi_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_op,
  input  wire logic [IDX_W-1:0]        in_key_slot,
  input  wire logic [VAL_W-1:0]        in_key_time,
  input  wire logic signed [VAL_W-1:0] in_key_x,
  input  wire logic signed [VAL_W-1:0] in_key_y,
  input  wire logic signed [VAL_W-1:0] in_key_z,
  input  wire logic [VAL_W-1:0]        in_query_time,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VAL_W-1:0]      out_x,
  output logic signed [VAL_W-1:0]      out_y,
  output logic signed [VAL_W-1:0]      out_z,
  output logic [IDX_W-1:0]             out_segment,
  output logic [1:0]                   out_status
);

  kvi_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [VAL_W-1:0]     query_r, query_nxt;
  kvi_key_t             prev_r, prev_nxt;
  kvi_key_t             end_r, end_nxt;
  logic [IDX_W-1:0]     seg_r, seg_nxt;
  logic [1:0]           stat_r, stat_nxt;
  logic [VAL_W-1:0]     res_x_r, res_x_nxt;
  logic [VAL_W-1:0]     res_y_r, res_y_nxt;
  logic [VAL_W-1:0]     res_z_r, res_z_nxt;
  logic [FRAC_BITS-1:0] factor_r, factor_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]     out_x_r, out_x_nxt;
  logic [VAL_W-1:0]     out_y_r, out_y_nxt;
  logic [VAL_W-1:0]     out_z_r, out_z_nxt;
  logic [IDX_W-1:0]     out_seg_r, out_seg_nxt;
  logic [1:0]           out_stat_r, out_stat_nxt;

  logic                 in_acc;
  logic                 key_we;
  kvi_key_t             key_wdata;
  logic [IDX_W-1:0]     rd_addr;
  kvi_key_t             rd_data;
  logic [CNT_W-1:0]     last_w;
  logic [IDX_W-1:0]     last_idx;
  logic                 hit;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_quo;
  logic                 mul_start;
  logic                 mul_done;
  logic [VAL_W-1:0]     mul_a;
  logic [VAL_W-1:0]     mul_b;
  logic signed [VAL_W-1:0] mul_res;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign key_we    = in_acc && (in_op == OP_LOAD);
  assign key_wdata = '{tstamp: in_key_time, x: in_key_x, y: in_key_y, z: in_key_z};

  // key count of zero acts as one, anything past the table as a full table
  always_comb begin
    last_w = count_r - CNT_W'(1);
    if (count_r == '0) begin
      last_idx = '0;
    end else if (count_r > CNT_W'(MAX_KEYS)) begin
      last_idx = IDX_W'(MAX_KEYS - 1);
    end else begin
      last_idx = last_w[IDX_W-1:0];
    end
  end

  assign hit      = (query_r < rd_data.tstamp);
  assign out_free = !out_valid_r || !out_stall;
  assign rd_addr  = (state_r == S_SCAN) ? (idx_r + IDX_W'(1)) : '0;

  kvi_key_ram u_ram (
    .clk     (clk),
    .we      (key_we),
    .wr_addr (in_key_slot),
    .wr_data (key_wdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kvi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (query_r - prev_r.tstamp),
    .den   (rd_data.tstamp - prev_r.tstamp),
    .done  (div_done),
    .quo   (div_quo)
  );

  kvi_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .factor (factor_r),
    .done   (mul_done),
    .res    (mul_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_op == OP_QUERY)) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          if ((last_idx == '0) || hit) begin
            state_nxt = S_OUT;
          end
        end else if (hit) begin
          state_nxt = S_DIV;
        end else if (idx_r == last_idx) begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          state_nxt = (comp_r == 2'd2) ? S_OUT : S_MUL_GO;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and output register
  always_comb begin
    idx_nxt      = idx_r;
    query_nxt    = query_r;
    prev_nxt     = prev_r;
    end_nxt      = end_r;
    seg_nxt      = seg_r;
    stat_nxt     = stat_r;
    res_x_nxt    = res_x_r;
    res_y_nxt    = res_y_r;
    res_z_nxt    = res_z_r;
    factor_nxt   = factor_r;
    comp_nxt     = comp_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_z_nxt    = out_z_r;
    out_seg_nxt  = out_seg_r;
    out_stat_nxt = out_stat_r;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    mul_a        = prev_r.x;
    mul_b        = end_r.x;
    out_valid_nxt = out_valid_r && out_stall;

    case (comp_r)
      2'd1: begin
        mul_a = prev_r.y;
        mul_b = end_r.y;
      end
      2'd2: begin
        mul_a = prev_r.z;
        mul_b = end_r.z;
      end
      default: begin
        mul_a = prev_r.x;
        mul_b = end_r.x;
      end
    endcase

    unique case (state_r)
      S_IDLE: begin
        query_nxt = in_query_time;
        idx_nxt   = '0;
      end
      S_FETCH: begin
        idx_nxt = '0;
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          res_x_nxt = rd_data.x;
          res_y_nxt = rd_data.y;
          res_z_nxt = rd_data.z;
          seg_nxt   = '0;
          if (last_idx == '0) begin
            stat_nxt = ST_SINGLE;
          end else if (hit) begin
            stat_nxt = ST_BEFORE;
          end else begin
            prev_nxt = rd_data;
            idx_nxt  = idx_r + IDX_W'(1);
          end
        end else if (hit) begin
          seg_nxt   = idx_r - IDX_W'(1);
          end_nxt   = rd_data;
          div_start = 1'b1;
        end else if (idx_r == last_idx) begin
          res_x_nxt = rd_data.x;
          res_y_nxt = rd_data.y;
          res_z_nxt = rd_data.z;
          seg_nxt   = idx_r - IDX_W'(1);
          stat_nxt  = ST_AFTER;
        end else begin
          prev_nxt = rd_data;
          idx_nxt  = idx_r + IDX_W'(1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          factor_nxt = div_quo;
          comp_nxt   = 2'd0;
        end
      end
      S_MUL_GO: begin
        mul_start = 1'b1;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          case (comp_r)
            2'd1:    res_y_nxt = mul_res;
            2'd2:    res_z_nxt = mul_res;
            default: res_x_nxt = mul_res;
          endcase
          comp_nxt = comp_r + 2'd1;
          stat_nxt = ST_INTERP;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_z_nxt     = res_z_r;
          out_seg_nxt   = seg_r;
          out_stat_nxt  = stat_r;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_data;
      end
    end
    idx_r      <= idx_nxt;
    query_r    <= query_nxt;
    prev_r     <= prev_nxt;
    end_r      <= end_nxt;
    seg_r      <= seg_nxt;
    stat_r     <= stat_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_z_r    <= res_z_nxt;
    factor_r   <= factor_nxt;
    comp_r     <= comp_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_seg_r  <= out_seg_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_z       = out_z_r;
  assign out_segment = out_seg_r;
  assign out_status  = out_stat_r;

  `KVI_ASSERT(a_div_done_in_div, div_done |-> (state_r == S_DIV), "divider done out of turn")
  `KVI_ASSERT(a_mul_done_in_wait, mul_done |-> (state_r == S_MUL_WAIT), "blend done out of turn")
  `KVI_ASSERT(a_query_blocks, (in_acc && (in_op == OP_QUERY)) |=> in_stall, "query not blocking")
  `KVI_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule

`default_nettype wire

FILE: rtl/kvi_key_ram.sv
// ----------------------------------------------------------------------------
// Key table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvi_key_ram
  import kvi_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire kvi_key_t       wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output kvi_key_t            rd_data
);

  kvi_key_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/kvi_div.sv
// ----------------------------------------------------------------------------
// Interpolation factor divider
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
`default_nettype none

module kvi_div
  import kvi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [VAL_W-1:0]     num,
  input  wire logic [VAL_W-1:0]     den,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      quo
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VAL_W-1:0]      rem_r, rem_nxt;
  logic [VAL_W-1:0]      den_r, den_nxt;
  logic [FRAC_BITS-1:0]  quo_r, quo_nxt;
  logic [VAL_W:0]        rem_shl;
  logic [VAL_W:0]        rem_sub;

  // num is below den, so the partial remainder always fits in VAL_W bits
  assign rem_shl = {rem_r, 1'b0};
  assign rem_sub = rem_shl - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(FRAC_BITS);
      rem_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!rem_sub[VAL_W]) begin
        rem_nxt = rem_sub[VAL_W-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shl[VAL_W-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

FILE: rtl/kvi_mul.sv
// ----------------------------------------------------------------------------
// Component blend unit
// start + floor((end - start) * factor / 2^FRAC_BITS), three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module kvi_mul
  import kvi_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [VAL_W-1:0] a,
  input  wire logic signed [VAL_W-1:0] b,
  input  wire logic [FRAC_BITS-1:0]    factor,
  output logic                         done,
  output logic signed [VAL_W-1:0]      res
);

  logic                      v1_r, v2_r, v3_r;
  logic signed [VAL_W:0]     diff_r;
  logic [FRAC_BITS-1:0]      fac_r;
  logic [VAL_W-1:0]          a1_r, a2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [VAL_W-1:0]          res_r;
  logic [PROD_W-1:0]         sum_w;

  // arithmetic shift gives the floor toward minus infinity
  assign sum_w = {{(PROD_W-VAL_W){a2_r[VAL_W-1]}}, a2_r} + (prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    diff_r <= {b[VAL_W-1], b} - {a[VAL_W-1], a};
    fac_r  <= factor;
    a1_r   <= a;
    prod_r <= diff_r * $signed({1'b0, fac_r});
    a2_r   <= a1_r;
    res_r  <= sum_w[VAL_W-1:0];
  end

  assign done = v3_r;
  assign res  = res_r;

endmodule

`default_nettype wire

FILE: verif/tb_keyframe_vector_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe vector interpolator testbench
// Loads key tables, runs queries against an in-bench interpolation predictor
// and checks every result field by field, over several key_count settings and
// sender/receiver idling patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_keyframe_vector_interpolator;
  import kvi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 128;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
    logic [IDX_W-1:0]        seg;
    logic [1:0]              status;
  } vec_result_t;

  typedef enum int {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [IDX_W-1:0]        slot;
    logic [VAL_W-1:0]        t;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
    logic [VAL_W-1:0]        q;
    logic [CNT_W-1:0]        kc;
    bit                      has_want;
    vec_result_t             want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CNT_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_op;
  logic [IDX_W-1:0]        in_key_slot;
  logic [VAL_W-1:0]        in_key_time;
  logic signed [VAL_W-1:0] in_key_x;
  logic signed [VAL_W-1:0] in_key_y;
  logic signed [VAL_W-1:0] in_key_z;
  logic [VAL_W-1:0]        in_query_time;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_x;
  logic signed [VAL_W-1:0] out_y;
  logic signed [VAL_W-1:0] out_z;
  logic [IDX_W-1:0]        out_segment;
  logic [1:0]              out_status;

  // predictor copy of the key table and the count register
  logic [VAL_W-1:0]        key_time_tbl [MAX_KEYS];
  logic signed [VAL_W-1:0] key_x_tbl [MAX_KEYS];
  logic signed [VAL_W-1:0] key_y_tbl [MAX_KEYS];
  logic signed [VAL_W-1:0] key_z_tbl [MAX_KEYS];
  logic [CNT_W-1:0]        key_count_cfg;

  vec_result_t awaited_vectors [$];
  stim_row_t   directed_rows [$];

  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int loads_sent;
  int queries_sent;
  int cfg_writes;
  int holds_done;
  int hold_left;
  bit hold_pending;
  int status_seen [4];
  int cycle_count;

  keyframe_vector_interpolator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_key_slot   (in_key_slot),
    .in_key_time   (in_key_time),
    .in_key_x      (in_key_x),
    .in_key_y      (in_key_y),
    .in_key_z      (in_key_z),
    .in_query_time (in_query_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_segment   (out_segment),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic vec_result_t key_result(input int k, input int seg, input logic [1:0] st);
    vec_result_t r;
    r.x      = key_x_tbl[k];
    r.y      = key_y_tbl[k];
    r.z      = key_z_tbl[k];
    r.seg    = IDX_W'(seg);
    r.status = st;
    return r;
  endfunction

  // start + floor(diff * factor / 2^FRAC_BITS), floor toward minus infinity
  function automatic logic [VAL_W-1:0] blend(input logic signed [VAL_W-1:0] a,
                                             input logic signed [VAL_W-1:0] b,
                                             input longint fct);
    longint s;
    longint d;
    longint p;
    s = a;
    d = longint'(b) - s;
    p = d * fct;
    return VAL_W'(s + (p >>> FRAC_BITS));
  endfunction

  function automatic vec_result_t interpolate_key(input logic [VAL_W-1:0] qt);
    vec_result_t      r;
    int               n;
    int               i;
    int               seg;
    bit               found;
    logic [VAL_W-1:0] t0;
    logic [VAL_W-1:0] dt;
    longint           fct;
    n = key_count_cfg;
    if (n < 1) n = 1;
    if (n > MAX_KEYS) n = MAX_KEYS;
    if (n == 1) return key_result(0, 0, ST_SINGLE);
    if (qt < key_time_tbl[0]) return key_result(0, 0, ST_BEFORE);
    seg = 0;
    found = 1'b0;
    for (i = 0; i + 1 < n; i++) begin
      if (!found && qt < key_time_tbl[i+1]) begin
        seg = i;
        found = 1'b1;
      end
    end
    if (!found) return key_result(n - 1, n - 2, ST_AFTER);
    t0 = key_time_tbl[seg];
    dt = key_time_tbl[seg+1] - t0;
    fct = (dt != 0) ? (longint'(qt - t0) << FRAC_BITS) / longint'(dt) : 0;
    r.x      = blend(key_x_tbl[seg], key_x_tbl[seg+1], fct);
    r.y      = blend(key_y_tbl[seg], key_y_tbl[seg+1], fct);
    r.z      = blend(key_z_tbl[seg], key_z_tbl[seg+1], fct);
    r.seg    = IDX_W'(seg);
    r.status = ST_INTERP;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int clamp_count(input logic [CNT_W-1:0] kc);
    if (kc < 1) return 1;
    if (kc > MAX_KEYS) return MAX_KEYS;
    return kc;
  endfunction

  // one transaction on the input channel; the predictor sees it when accepted
  task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
                           input logic [VAL_W-1:0] t, input logic [VAL_W-1:0] x,
                           input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] z,
                           input logic [VAL_W-1:0] q, input bit has_want,
                           input vec_result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    if (op == OP_LOAD) begin
      in_key_slot   <= slot;
      in_key_time   <= t;
      in_key_x      <= x;
      in_key_y      <= y;
      in_key_z      <= z;
      in_query_time <= $urandom;
    end else begin
      in_key_slot   <= IDX_W'($urandom);
      in_key_time   <= $urandom;
      in_key_x      <= $urandom;
      in_key_y      <= $urandom;
      in_key_z      <= $urandom;
      in_query_time <= q;
    end
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (op == OP_LOAD) begin
      key_time_tbl[slot] = t;
      key_x_tbl[slot]    = x;
      key_y_tbl[slot]    = y;
      key_z_tbl[slot]    = z;
      loads_sent++;
    end else begin
      awaited_vectors.insert(awaited_vectors.size(), has_want ? want : interpolate_key(q));
      queries_sent++;
    end
  endtask

  task automatic wait_drained();
    while (awaited_vectors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_count(input logic [CNT_W-1:0] kc);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= kc;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_count_cfg = kc;
    cfg_writes++;
  endtask

  // nondecreasing key times over slots 0..n-1 with random vectors
  task automatic load_key_set(input int n);
    longint           step_max;
    longint           span;
    longint           step;
    logic [VAL_W-1:0] t;
    int               s;
    case ($urandom_range(3))
      0:       step_max = 15;
      1:       step_max = 'hFFFF;
      2:       step_max = 'hFF_FFFF;
      default: step_max = 'h3FF_FFFF;
    endcase
    span = step_max * n;
    t = $urandom_range(32'hFFFF_FFFF - span[31:0]);
    for (s = 0; s < n; s++) begin
      send_item(OP_LOAD, IDX_W'(s), t, rand_value(), rand_value(), rand_value(),
                '0, 1'b0, '0);
      step = ($urandom_range(9) == 0) ? 0 : $urandom_range(step_max[31:0]);
      t = t + step[31:0];
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_query_time(input int n);
    int               r;
    int               i;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    r = $urandom_range(99);
    if (n < 2 || r >= 85) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return 32'hFFFF_FFFF;
        default: return $urandom;
      endcase
    end
    if (r < 55) begin
      i  = $urandom_range(n - 2);
      lo = key_time_tbl[i];
      hi = key_time_tbl[i+1];
      if (hi > lo) return lo + $urandom_range(hi - lo - 1);
      return lo;
    end
    if (r < 70) return key_time_tbl[$urandom_range(n - 1)];
    if (r < 78) return (key_time_tbl[0] == 0) ? '0 : key_time_tbl[0] - 1;
    return key_time_tbl[n-1] + $urandom_range(3);
  endfunction

  task automatic random_phase(input int items, input logic [CNT_W-1:0] kc,
                              input bit full_load, input bit with_hold);
    int n;
    int start;
    int r;
    bit hold_asked;
    set_key_count(kc);
    n = clamp_count(kc);
    start = items_sent;
    hold_asked = 1'b0;
    load_key_set(full_load ? MAX_KEYS : n);
    while (items_sent - start < items) begin
      if (with_hold && !hold_asked && items_sent - start >= items / 2) begin
        hold_pending = 1'b1;
        hold_asked = 1'b1;
      end
      r = $urandom_range(99);
      if (r < ((n > 16) ? 1 : 6)) begin
        load_key_set(n);
      end else if (r < 12) begin
        // stray load that can break the time ordering
        send_item(OP_LOAD, IDX_W'($urandom), $urandom, rand_value(), rand_value(),
                  rand_value(), '0, 1'b0, '0);
      end else begin
        send_item(OP_QUERY, '0, '0, '0, '0, '0, pick_query_time(n), 1'b0, '0);
      end
    end
  endtask

  task automatic add_load(input logic [IDX_W-1:0] slot, input logic [VAL_W-1:0] t,
                          input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                          input logic [VAL_W-1:0] z);
    stim_row_t row;
    row = '{kind: ROW_LOAD, slot: slot, t: t, x: x, y: y, z: z, q: '0, kc: '0,
            has_want: 1'b0, want: '0};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_query(input logic [VAL_W-1:0] q);
    stim_row_t row;
    row = '{kind: ROW_QUERY, slot: '0, t: '0, x: '0, y: '0, z: '0, q: q, kc: '0,
            has_want: 1'b0, want: '0};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_check(input logic [VAL_W-1:0] q, input logic [VAL_W-1:0] x,
                           input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] z,
                           input logic [IDX_W-1:0] seg, input logic [1:0] st);
    stim_row_t row;
    row = '{kind: ROW_QUERY, slot: '0, t: '0, x: '0, y: '0, z: '0, q: q, kc: '0,
            has_want: 1'b1, want: '{x: x, y: y, z: z, seg: seg, status: st}};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_cfg(input logic [CNT_W-1:0] kc);
    stim_row_t row;
    row = '{kind: ROW_CFG, slot: '0, t: '0, x: '0, y: '0, z: '0, q: '0, kc: kc,
            has_want: 1'b0, want: '0};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
      holds_done++;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_vectors.size() == 0) begin
        report_mismatch($sformatf("result with none pending: x=%h y=%h z=%h seg=%0d st=%0d",
                                  out_x, out_y, out_z, out_segment, out_status));
      end else begin
        want = awaited_vectors.pop_front();
        if (out_x !== want.x)
          report_mismatch($sformatf("out_x got %h want %h", out_x, want.x));
        if (out_y !== want.y)
          report_mismatch($sformatf("out_y got %h want %h", out_y, want.y));
        if (out_z !== want.z)
          report_mismatch($sformatf("out_z got %h want %h", out_z, want.z));
        if (out_segment !== want.seg)
          report_mismatch($sformatf("out_segment got %0d want %0d", out_segment, want.seg));
        if (out_status !== want.status)
          report_mismatch($sformatf("out_status got %0d want %0d", out_status, want.status));
        status_seen[want.status]++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, awaited_vectors.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_op         = OP_LOAD;
    in_key_slot   = '0;
    in_key_time   = '0;
    in_key_x      = '0;
    in_key_y      = '0;
    in_key_z      = '0;
    in_query_time = '0;
    out_stall     = 1'b0;
    hold_pending  = 1'b0;
    hold_left     = 0;
    holds_done    = 0;
    mismatch_count = 0;
    items_sent    = 0;
    loads_sent    = 0;
    queries_sent  = 0;
    cfg_writes    = 0;
    status_seen   = '{default: 0};
    key_count_cfg = 1;
    for (int i = 0; i < MAX_KEYS; i++) begin
      key_time_tbl[i] = '0;
      key_x_tbl[i]    = '0;
      key_y_tbl[i]    = '0;
      key_z_tbl[i]    = '0;
    end
    send_idle_pct = 10;
    recv_idle_pct = 65;

    // key_count is 1 out of reset, so the first query returns key 0 as is
    add_load(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    add_check(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, ST_SINGLE);
    add_load(1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
    add_load(2, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_cfg(3);
    add_check(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, ST_BEFORE);
    add_check(32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, ST_BEFORE);
    add_check(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, ST_INTERP);
    add_query(32'h0002_0000);
    add_query(32'h0002_FFFF);
    add_check(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 1, ST_INTERP);
    add_query(32'h7FFF_FFFF);
    add_query(32'hFFFF_FFFE);
    // equal to the last key time counts as past the end
    add_check(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, ST_AFTER);
    // a count of zero behaves as a single key
    add_cfg(0);
    add_check(32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, ST_SINGLE);
    add_cfg(2);
    add_check(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 0, ST_AFTER);
    // key 1 now earlier than key 0
    add_load(1, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    add_cfg(3);
    add_query(32'h0002_0000);
    add_check(32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, ST_BEFORE);
    add_query(32'h0000_9000);
    add_load(2, 32'h0001_0000, 32'h0000_0123, 32'hFFFF_FEDC, 32'h00C0_FFEE);
    add_check(32'h0001_0000, 32'h0000_0123, 32'hFFFF_FEDC, 32'h00C0_FFEE, 1, ST_AFTER);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          set_key_count(directed_rows[i].kc);
        end
        ROW_LOAD: begin
          send_item(OP_LOAD, directed_rows[i].slot, directed_rows[i].t,
                    directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                    '0, 1'b0, '0);
        end
        default: begin
          send_item(OP_QUERY, '0, '0, '0, '0, '0, directed_rows[i].q,
                    directed_rows[i].has_want, directed_rows[i].want);
        end
      endcase
    end

    // the first random phase fills every slot, so no later query reads an empty one
    random_phase(300, 64, 1'b1, 1'b0);
    random_phase(200, 5, 1'b0, 1'b0);
    random_phase(150, 127, 1'b0, 1'b0);

    send_idle_pct = 65;
    recv_idle_pct = 10;
    random_phase(200, 2, 1'b0, 1'b0);
    random_phase(100, 0, 1'b0, 1'b0);
    random_phase(200, 33, 1'b0, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(250, 64, 1'b0, 1'b1);
    random_phase(200, 9, 1'b0, 1'b1);
    random_phase(100, 12, 1'b0, 1'b0);

    in_valid <= 1'b0;
    wait_drained();
    if (awaited_vectors.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_vectors.size()));

    $display("ran %0d loads and %0d queries across %0d key_count writes, %0d long output holds",
             loads_sent, queries_sent, cfg_writes, holds_done);
    $display("checked %0d interpolated, %0d single key, %0d before first, %0d after last",
             status_seen[ST_INTERP], status_seen[ST_SINGLE], status_seen[ST_BEFORE],
             status_seen[ST_AFTER]);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
